// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define LCDPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define LCDPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lcdpi_pkg.sv -----
// Types, codes and constants of the character LCD pin sequencer.
package lcdpi_pkg;

  // Request kinds carried on the input channel
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Steps of the init and clear sequences
  localparam logic [2:0] STEP_LONG_WAIT  = 3'd0;
  localparam logic [2:0] STEP_FUNC_SET   = 3'd1;
  localparam logic [2:0] STEP_SHORT_WAIT = 3'd2;
  localparam logic [2:0] STEP_DISP_ON    = 3'd3;
  localparam logic [2:0] STEP_ENTRY_MODE = 3'd4;
  localparam logic [2:0] STEP_INIT_CLEAR = 3'd5;
  localparam logic [2:0] STEP_CLR_POLL   = 3'd6;
  localparam logic [2:0] STEP_CLR_CMD    = 3'd7;

  // Lengths of the timed phases, in delay units
  localparam logic [3:0] LONG_WAIT_UNITS  = 4'd15;
  localparam logic [3:0] SHORT_WAIT_UNITS = 4'd5;
  localparam logic [3:0] POLL_UNITS       = 4'd5;
  localparam logic [3:0] SETUP_UNITS      = 4'd1;
  localparam logic [3:0] STROBE_UNITS     = 4'd5;
  localparam logic [3:0] NO_UNITS         = 4'd0;

  localparam logic [15:0] UNIT_TICKS_RST = 16'd1000;

  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;

  // Pin sequencer phase
  typedef enum logic [5:0] {
    SUB_IDLE   = 6'b000001,
    SUB_POLL   = 6'b000010,
    SUB_GAP    = 6'b000100,
    SUB_SETUP  = 6'b001000,
    SUB_STROBE = 6'b010000,
    SUB_WAIT   = 6'b100000
  } sub_t;

  // One registered input transaction
  typedef struct packed {
    logic       req;
    logic [1:0] op;
    logic [7:0] byte_value;
    logic       busy;
  } item_t;

  // One result transaction, rs in the lowest bit
  typedef struct packed {
    logic       done_res;
    logic       ready_res;
    logic       bus_drive;
    logic [7:0] bus_out;
    logic       en;
    logic       rw;
    logic       rs;
  } result_t;

  // Delay timer outcome for one tick
  typedef struct packed {
    logic        expired;
    logic [15:0] tick_nxt;
    logic [3:0]  unit_nxt;
  } tmr_t;

  // Command byte sent at a sequence step
  function automatic logic [7:0] seq_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      STEP_FUNC_SET:   b = CMD_FUNC_SET;
      STEP_DISP_ON:    b = CMD_DISP_ON;
      STEP_ENTRY_MODE: b = CMD_ENTRY_MODE;
      STEP_INIT_CLEAR: b = CMD_CLEAR;
      STEP_CLR_CMD:    b = CMD_CLEAR;
      default:         b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/lcdpi_timer.sv -----
// Delay timer step: ticks within a unit and units within a phase.
module lcdpi_timer (
  input  logic [15:0]   unit_ticks,
  input  logic [15:0]   tick_count,
  input  logic [3:0]    unit_count,
  output lcdpi_pkg::tmr_t tmr
);
  import lcdpi_pkg::*;

  logic [15:0] limit;
  logic [15:0] tick_inc;

  // A zero setting counts as one tick per unit
  assign limit    = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
  assign tick_inc = tick_count + 16'd1;

  always_comb begin
    tmr.expired  = 1'b0;
    tmr.tick_nxt = tick_inc;
    tmr.unit_nxt = unit_count;
    if (tick_inc >= limit) begin
      tmr.tick_nxt = 16'd0;
      if (unit_count <= 4'd1) begin
        tmr.unit_nxt = 4'd0;
        tmr.expired  = 1'b1;
      end else begin
        tmr.unit_nxt = unit_count - 4'd1;
      end
    end
  end

endmodule

// ----- src/lcdpi_seq.sv -----
// Pin sequencer state and its next-state logic, one tick per transaction.
module lcdpi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [15:0]         unit_ticks,
  input  lcdpi_pkg::item_t    item,
  output lcdpi_pkg::result_t  res
);
  import lcdpi_pkg::*;

  sub_t        sub_r, sub_nxt;
  logic        seq_r, seq_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  unit_r, unit_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_sel_r, held_sel_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        pin_en_r, pin_en_nxt;
  logic        pin_rs_r, pin_rs_nxt;
  logic        pin_rw_r, pin_rw_nxt;
  logic        done;
  logic        do_disp;
  logic [2:0]  disp_step;
  logic        drive;
  tmr_t        tmr;

  lcdpi_timer u_timer (
    .unit_ticks (unit_ticks),
    .tick_count (tick_r),
    .unit_count (unit_r),
    .tmr        (tmr)
  );

  // Next state for one tick
  always_comb begin
    sub_nxt       = sub_r;
    seq_nxt       = seq_r;
    tick_nxt      = tick_r;
    unit_nxt      = unit_r;
    held_byte_nxt = held_byte_r;
    held_sel_nxt  = held_sel_r;
    step_nxt      = step_r;
    pin_en_nxt    = pin_en_r;
    pin_rs_nxt    = pin_rs_r;
    pin_rw_nxt    = pin_rw_r;
    done          = 1'b0;
    do_disp       = 1'b0;
    disp_step     = step_r;

    unique case (sub_r)
      SUB_IDLE: begin
        if (item.req) begin
          if (item.op == OP_CMD || item.op == OP_DATA) begin
            seq_nxt       = 1'b0;
            held_byte_nxt = item.byte_value;
            held_sel_nxt  = (item.op == OP_DATA);
            pin_en_nxt    = 1'b1;
            pin_rs_nxt    = 1'b0;
            pin_rw_nxt    = 1'b1;
            sub_nxt       = SUB_POLL;
            tick_nxt      = 16'd0;
            unit_nxt      = POLL_UNITS;
          end else begin
            seq_nxt   = 1'b1;
            do_disp   = 1'b1;
            disp_step = (item.op == OP_INIT) ? STEP_LONG_WAIT : STEP_CLR_POLL;
          end
        end
      end
      SUB_POLL: begin
        tick_nxt = tmr.tick_nxt;
        unit_nxt = tmr.unit_nxt;
        if (tmr.expired) begin
          pin_en_nxt = 1'b0;
          pin_rs_nxt = 1'b0;
          pin_rw_nxt = 1'b1;
          tick_nxt   = 16'd0;
          if (item.busy) begin
            sub_nxt  = SUB_GAP;
            unit_nxt = NO_UNITS;
          end else if (seq_r && step_r == STEP_CLR_POLL) begin
            // clear starts with a poll alone, then queues its command
            step_nxt      = STEP_CLR_CMD;
            held_byte_nxt = seq_byte(STEP_CLR_CMD);
            held_sel_nxt  = 1'b0;
            sub_nxt       = SUB_GAP;
            unit_nxt      = NO_UNITS;
          end else begin
            pin_rs_nxt = held_sel_r;
            pin_rw_nxt = 1'b0;
            sub_nxt    = SUB_SETUP;
            unit_nxt   = SETUP_UNITS;
          end
        end
      end
      SUB_GAP: begin
        pin_en_nxt = 1'b1;
        pin_rs_nxt = 1'b0;
        pin_rw_nxt = 1'b1;
        sub_nxt    = SUB_POLL;
        tick_nxt   = 16'd0;
        unit_nxt   = POLL_UNITS;
      end
      SUB_SETUP: begin
        tick_nxt = tmr.tick_nxt;
        unit_nxt = tmr.unit_nxt;
        if (tmr.expired) begin
          pin_en_nxt = 1'b1;
          pin_rs_nxt = held_sel_r;
          pin_rw_nxt = 1'b0;
          sub_nxt    = SUB_STROBE;
          tick_nxt   = 16'd0;
          unit_nxt   = STROBE_UNITS;
        end
      end
      SUB_STROBE: begin
        tick_nxt = tmr.tick_nxt;
        unit_nxt = tmr.unit_nxt;
        if (tmr.expired) begin
          pin_en_nxt = 1'b0;
          pin_rs_nxt = held_sel_r;
          pin_rw_nxt = 1'b0;
          if (!seq_r || step_r == STEP_INIT_CLEAR) begin
            sub_nxt = SUB_IDLE;
            seq_nxt = 1'b0;
            done    = 1'b1;
          end else if (step_r == STEP_CLR_CMD) begin
            sub_nxt  = SUB_WAIT;
            tick_nxt = 16'd0;
            unit_nxt = SHORT_WAIT_UNITS;
          end else begin
            do_disp   = 1'b1;
            disp_step = step_r + 3'd1;
          end
        end
      end
      SUB_WAIT: begin
        tick_nxt = tmr.tick_nxt;
        unit_nxt = tmr.unit_nxt;
        if (tmr.expired) begin
          if (step_r == STEP_CLR_CMD) begin
            sub_nxt = SUB_IDLE;
            seq_nxt = 1'b0;
            done    = 1'b1;
          end else begin
            do_disp   = 1'b1;
            disp_step = step_r + 3'd1;
          end
        end
      end
      default: begin
        sub_nxt    = SUB_IDLE;
        seq_nxt    = 1'b0;
        pin_en_nxt = 1'b0;
      end
    endcase

    // Move to the next step of a sequence
    if (do_disp) begin
      step_nxt = disp_step;
      tick_nxt = 16'd0;
      priority if (disp_step == STEP_LONG_WAIT || disp_step == STEP_SHORT_WAIT) begin
        pin_en_nxt = 1'b0;
        sub_nxt    = SUB_WAIT;
        unit_nxt   = (disp_step == STEP_LONG_WAIT) ? LONG_WAIT_UNITS : SHORT_WAIT_UNITS;
      end else begin
        if (disp_step != STEP_CLR_POLL) begin
          held_byte_nxt = seq_byte(disp_step);
          held_sel_nxt  = 1'b0;
        end
        pin_en_nxt = 1'b1;
        pin_rs_nxt = 1'b0;
        pin_rw_nxt = 1'b1;
        sub_nxt    = SUB_POLL;
        unit_nxt   = POLL_UNITS;
      end
    end
  end

  // Result shows the state after the tick
  assign drive = (sub_nxt == SUB_SETUP) || (sub_nxt == SUB_STROBE);

  always_comb begin
    res.done_res  = done;
    res.ready_res = (sub_nxt == SUB_IDLE);
    res.bus_drive = drive;
    res.bus_out   = drive ? held_byte_nxt : 8'h00;
    res.en        = pin_en_nxt;
    res.rw        = pin_rw_nxt;
    res.rs        = pin_rs_nxt;
  end

  // State registers, advanced once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= SUB_IDLE;
      seq_r       <= 1'b0;
      tick_r      <= 16'd0;
      unit_r      <= 4'd0;
      held_byte_r <= 8'h00;
      held_sel_r  <= 1'b0;
      step_r      <= STEP_LONG_WAIT;
      pin_en_r    <= 1'b0;
      pin_rs_r    <= 1'b0;
      pin_rw_r    <= 1'b0;
    end else if (step_en) begin
      sub_r       <= sub_nxt;
      seq_r       <= seq_nxt;
      tick_r      <= tick_nxt;
      unit_r      <= unit_nxt;
      held_byte_r <= held_byte_nxt;
      held_sel_r  <= held_sel_nxt;
      step_r      <= step_nxt;
      pin_en_r    <= pin_en_nxt;
      pin_rs_r    <= pin_rs_nxt;
      pin_rw_r    <= pin_rw_nxt;
    end
  end

endmodule

// ----- src/char_lcd_parallel_interface.sv -----
// Top level of the 8-bit character LCD pin sequencer.
//
//  Channel | Direction | Payload
//  in_     | slave     | tick: req, byte_value, bus_in in tdata; op in tuser
//  out_    | master    | pins and status for that tick in tdata
//  cfg_    | slave     | unit_ticks, sequencer ticks per delay unit
//
// One transaction is one sequencer tick; one is taken every clock cycle
// unless out_tready stalls. An input register feeds the sequencer step into
// the result register. The sequencer state advances when an input moves on.
// A stalled out_tready holds the result and back-pressures in_tready.
// Synchronous reset clears all control state; unit_ticks resets to 1000.
module char_lcd_parallel_interface (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // req, byte_value[7:0], bus_in[7:0], zero pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // rs, rw, en, bus_out[7:0], bus_drive,
                                  // ready_res, done_res, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lcdpi_pkg::*;

  logic        in_valid_r;
  item_t       item_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res;
  logic [15:0] unit_ticks_r;
  logic        advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
    end else if (cfg_valid) begin
      unit_ticks_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= (in_tvalid && in_tready) || (in_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req        <= in_tdata[0];
      item_r.op         <= in_tuser;
      item_r.byte_value <= in_tdata[8:1];
      item_r.busy       <= in_tdata[16];
    end
  end

  lcdpi_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .unit_ticks (unit_ticks_r),
    .item       (item_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

// ----- src/lcdpi_check.sv -----
// Port-level checker for the LCD pin sequencer, bound to the top level.
`include "assert_macros.svh"

module lcdpi_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic       en;
  logic [7:0] bus_out;
  logic       bus_drive;
  logic       ready_res;
  logic       done_res;
  logic       stall;

  // Result fields, rs in the lowest bit
  assign en        = out_tdata[2];
  assign bus_out   = out_tdata[10:3];
  assign bus_drive = out_tdata[11];
  assign ready_res = out_tdata[12];
  assign done_res  = out_tdata[13];
  assign stall     = out_tvalid && !out_tready;

  // Nothing comes out in the cycle after reset
  `LCDPI_ASSERT_ALWAYS(a_rst_quiet, $past(!rst_n) |-> !out_tvalid, "result valid after reset")

  // A released bus reads back as zero
  `LCDPI_ASSERT(a_bus_zero, out_tvalid && !bus_drive |-> bus_out == 8'h00, "bus_out set while released")

  // Idle means no strobe and no bus drive
  `LCDPI_ASSERT(a_idle_quiet, out_tvalid && ready_res |-> !bus_drive && !en, "pins active while idle")

  // A finished request always leaves the block idle
  `LCDPI_ASSERT(a_done_idle, out_tvalid && done_res |-> ready_res, "done without idle")

  // A stalled result holds
  `LCDPI_ASSERT(a_out_hold, stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind char_lcd_parallel_interface lcdpi_check u_lcdpi_check (.*);
